/* hw/rtl/lpkc_pkg.sv */
// Package for the linear-probe key counter: table geometry, op codes,
// the engine result record and the used-slot formatting helper. No dependencies.
`default_nettype none

package lpkc_pkg;

  // Table size; must be a power of two so the home slot is a bit-select.
  localparam int SLOTS   = 64;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int OCC_W   = $clog2(SLOTS + 1);
  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int USED_W  = 7;
  localparam int ENTRY_W = KEY_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ACCOUNT = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               found;
    logic               table_full;
    logic [USED_W-1:0]  used_slots;
  } result_t;

  // Occupied total modulo 128.
  function automatic logic [USED_W-1:0] used_of(input logic [OCC_W-1:0] n);
    logic [OCC_W+USED_W-1:0] ext;
    ext = {{USED_W{1'b0}}, n};
    return ext[USED_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/linear_probe_key_counter_core.sv */
// Top level of the linear-probe key counter: stream ports, APB register and
// output register around the probe engine. Uses lpkc_pkg and lpkc_engine.
//
//  channel   | dir | handshake                 | payload
//  s_axis    | in  | tvalid/tready             | tdata: op[1:0], key[65:2], zero pad
//  m_axis    | out | tvalid/tready             | tdata: count, has_room, found,
//            |     |                           |        table_full, used_slots
//  apb       | in  | psel/penable/pwrite/pready| region_cap at byte address 0
//
// Clear needs no probe; account and query walk P slots, where P is the
// number of slots probed (1..64), one entry RAM read per cycle on its one read port.
// Reset (synchronous, rst high) empties all slots at once through per-slot valid
// bits and sets region_cap to 8. A new item is taken once the engine hands its
// result to the output register, even while that register still waits on m_axis_tready.
`default_nettype none

module linear_probe_key_counter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // op[1:0], key[65:2], zero[71:66]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // count[15:0], has_room[16], found[17],
                                          // table_full[18], used_slots[25:19], zero[31:26]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic REG_CAP = 1'b0;

  logic [lpkc_pkg::COUNT_W-1:0] region_cap;
  logic                         cfg_wr;
  logic                         res_valid;
  logic                         res_take;
  lpkc_pkg::result_t            res;
  lpkc_pkg::result_t            out_res;
  logic                         out_room;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAP);
  assign prdata = (paddr[2] == REG_CAP) ? {16'd0, region_cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_cap <= lpkc_pkg::COUNT_W'(8);
    end else if (cfg_wr) begin
      region_cap <= pwdata[lpkc_pkg::COUNT_W-1:0];
    end
  end

  lpkc_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tdata[1:0]),
    .in_key   (s_axis_tdata[65:2]),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res)
  );

  // Load the output register when it is empty or being drained.
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res  <= res;
      out_room <= (res.count < region_cap);
    end
  end

  assign m_axis_tdata = {6'd0, out_res.used_slots, out_res.table_full, out_res.found,
                         out_room, out_res.count};

endmodule

`default_nettype wire

/* hw/rtl/lpkc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lpkc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 80
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/lpkc_engine.sv */
// Probe engine: walks the slot chain in the entry RAM, inserts or bumps the
// counter, keeps slot valid bits and the occupied total. Uses lpkc_pkg, lpkc_ram.
`default_nettype none

module lpkc_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [lpkc_pkg::KEY_W-1:0]  in_key,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output lpkc_pkg::result_t                res
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DONE} state_t;

  state_t                           state;
  logic [1:0]                       op_q;
  logic [lpkc_pkg::KEY_W-1:0]       key_q;
  logic [lpkc_pkg::IDX_W-1:0]       idx;
  logic [lpkc_pkg::IDX_W-1:0]       probes;
  logic [lpkc_pkg::SLOTS-1:0]       valid;
  logic [lpkc_pkg::OCC_W-1:0]       occ;

  logic [lpkc_pkg::ENTRY_W-1:0]     rd_data;
  logic [lpkc_pkg::ENTRY_W-1:0]     wr_data;
  logic [lpkc_pkg::IDX_W-1:0]       rd_addr;
  logic [lpkc_pkg::IDX_W-1:0]       home;
  logic [lpkc_pkg::KEY_W-1:0]       cur_key;
  logic [lpkc_pkg::COUNT_W-1:0]     cur_cnt;
  logic [lpkc_pkg::COUNT_W-1:0]     cnt_inc;
  logic [lpkc_pkg::OCC_W-1:0]       occ_inc;
  logic                             cur_valid;
  logic                             key_hit;
  logic                             is_acct;
  logic                             last_probe;
  logic                             wr_en;
  lpkc_pkg::result_t                look_res;

  always_comb begin
    home       = in_key[lpkc_pkg::IDX_W-1:0] ^ in_key[32 +: lpkc_pkg::IDX_W];
    cur_valid  = valid[idx];
    cur_key    = rd_data[lpkc_pkg::COUNT_W +: lpkc_pkg::KEY_W];
    cur_cnt    = rd_data[lpkc_pkg::COUNT_W-1:0];
    key_hit    = cur_valid && (cur_key == key_q);
    is_acct    = (op_q == lpkc_pkg::OP_ACCOUNT);
    cnt_inc    = (cur_cnt == lpkc_pkg::COUNT_MAX) ? cur_cnt
                                                  : cur_cnt + lpkc_pkg::COUNT_W'(1);
    occ_inc    = occ + lpkc_pkg::OCC_W'(1);
    last_probe = (probes == lpkc_pkg::IDX_W'(lpkc_pkg::SLOTS - 1));
    wr_en      = (state == S_LOOK) && is_acct && (!cur_valid || key_hit);
    wr_data    = {key_q, cur_valid ? cnt_inc : lpkc_pkg::COUNT_W'(1)};
    // Issue the home read on accept, else the next slot on the chain.
    rd_addr    = (state == S_IDLE) ? home : idx + lpkc_pkg::IDX_W'(1);
    in_ready   = (state == S_IDLE);
    res_valid  = (state == S_DONE);
  end

  // Result of the slot under probe, used when the chain ends here.
  always_comb begin
    look_res.found      = 1'b0;
    look_res.table_full = 1'b0;
    look_res.count      = '0;
    look_res.used_slots = lpkc_pkg::used_of(occ);
    if (!cur_valid) begin
      if (is_acct) begin
        look_res.count      = lpkc_pkg::COUNT_W'(1);
        look_res.used_slots = lpkc_pkg::used_of(occ_inc);
      end
    end else if (key_hit) begin
      look_res.found = 1'b1;
      look_res.count = is_acct ? cnt_inc : cur_cnt;
    end else begin
      look_res.table_full = is_acct && last_probe;
    end
  end

  lpkc_ram #(
    .DEPTH(lpkc_pkg::SLOTS),
    .WIDTH(lpkc_pkg::ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(idx),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      occ   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= in_op;
            key_q <= in_key;
            if (in_op == lpkc_pkg::OP_CLEAR) begin
              valid <= '0;
              occ   <= '0;
              res   <= '0;
              state <= S_DONE;
            end else begin
              idx    <= home;
              probes <= '0;
              state  <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!cur_valid || key_hit || last_probe) begin
            res   <= look_res;
            state <= S_DONE;
          end else begin
            idx    <= idx + lpkc_pkg::IDX_W'(1);
            probes <= probes + lpkc_pkg::IDX_W'(1);
          end
          // Empty slot ends the chain: insert on account.
          if (!cur_valid && is_acct) begin
            valid[idx] <= 1'b1;
            occ        <= occ_inc;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for linear_probe_key_counter_core: drives clear,
// account, query and spare-op items through the stream ports and checks every result.
// Depends on lpkc_pkg and the core RTL only.
`default_nettype none

module testbench;
  import lpkc_pkg::*;

  localparam logic [1:0] OP_SPARE        = 2'd3;
  localparam logic [2:0] ADDR_REGION_CAP = 3'd0;
  localparam int         CYCLE_LIMIT     = 2_000_000;
  localparam int         SETTLE_CYCLES   = SLOTS + 8;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               has_room;
    logic               found;
    logic               table_full;
    logic [USED_W-1:0]  used_slots;
  } tally_t;

  typedef struct {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    bit               typed;
    tally_t           want;
  } probe_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;   // op[1:0], key[65:2], zero[71:66]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // count[15:0], has_room[16], found[17],
                                    // table_full[18], used_slots[25:19]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  linear_probe_key_counter_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the key table and the cap register.
  logic [KEY_W-1:0]   shadow_key [SLOTS];
  logic [COUNT_W-1:0] shadow_cnt [SLOTS];
  bit                 shadow_live [SLOTS];
  int                 occupancy;
  logic [15:0]        cap_shadow;

  tally_t     tally_queue [$];
  probe_row_t probe_rows [$];
  logic [KEY_W-1:0] key_pool [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  full_seen = 0;
  int  saturated_seen = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_left = 0;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("mismatch on %s at result %0d: got %0h, want %0h",
             what, results_seen, got, want);
    mismatches++;
  endtask

  function automatic tally_t tally_apply(input logic [1:0] op, input logic [KEY_W-1:0] key);
    tally_t           r;
    logic [KEY_W-1:0] folded;
    int               home;
    int               idx;
    int               hit_at;
    int               free_at;
    r = '0;
    hit_at = -1;
    free_at = -1;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) shadow_live[i] = 1'b0;
      occupancy = 0;
    end else begin
      folded = key ^ (key >> 32);
      home = int'(folded % SLOTS);
      for (int p = 0; p < SLOTS && hit_at < 0 && free_at < 0; p++) begin
        idx = (home + p) % SLOTS;
        if (!shadow_live[idx]) free_at = idx;
        else if (shadow_key[idx] == key) hit_at = idx;
      end
      if (op == OP_ACCOUNT) begin
        if (hit_at < 0 && free_at < 0) begin
          r.table_full = 1'b1;
        end else begin
          if (hit_at >= 0) begin
            r.found = 1'b1;
          end else begin
            hit_at = free_at;
            shadow_live[hit_at] = 1'b1;
            shadow_key[hit_at] = key;
            shadow_cnt[hit_at] = '0;
            occupancy++;
          end
          if (shadow_cnt[hit_at] != COUNT_MAX) shadow_cnt[hit_at]++;
          r.count = shadow_cnt[hit_at];
        end
      end else if (hit_at >= 0) begin
        // spare op code behaves as a query
        r.found = 1'b1;
        r.count = shadow_cnt[hit_at];
      end
    end
    r.has_room = (r.count < cap_shadow);
    r.used_slots = USED_W'(occupancy);
    return r;
  endfunction

  function automatic int idle_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  // Called right after a rising edge; returns at the edge that takes the item.
  task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                           input bit typed, input tally_t typed_want);
    int     gap;
    tally_t want;
    gap = idle_len(tx_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, key, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = tally_apply(op, key);
    tally_queue.push_back(typed ? typed_want : want);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tally_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_region_cap(input logic [31:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_REGION_CAP;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    cap_shadow = word[15:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // read back the register
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {16'b0, cap_shadow})
      flag_mismatch("region_cap readback", 64'(prdata), 64'(cap_shadow));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [KEY_W-1:0] key, input bit typed,
                         input int count, input bit room, input bit found, input bit full,
                         input int used);
    probe_row_t row;
    row.op = op;
    row.key = key;
    row.typed = typed;
    row.want = '{count: COUNT_W'(count), has_room: room, found: found,
                 table_full: full, used_slots: USED_W'(used)};
    probe_rows.push_back(row);
  endtask

  task automatic run_random(input int items, input int pool_size, input int clear_odds);
    logic [KEY_W-1:0] k;
    logic [1:0]       op;
    int               r;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) begin
      k = any_key();
      r = $urandom_range(0, 19);
      if (r == 0) k = '0;
      else if (r == 1) k = '1;
      else if (r < 8) k[5:0] = k[37:32] ^ 6'($urandom_range(0, 3));  // crowd a few homes
      key_pool.push_back(k);
    end
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 999);
      k = key_pool[$urandom_range(0, pool_size - 1)];
      if (r < clear_odds) begin
        op = OP_CLEAR;
        k = any_key();
      end else if (r < 650) begin
        op = OP_ACCOUNT;
      end else if (r < 700) begin
        op = OP_ACCOUNT;
        k = any_key();
      end else if (r < 970) begin
        op = OP_QUERY;
        if ($urandom_range(0, 4) == 0) k = any_key();
      end else begin
        op = OP_SPARE;
      end
      send_item(op, k, 1'b0, '0);
    end
    wait_idle();
  endtask

  always @(posedge clk) begin : stall_gen
    int stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      stall = idle_len(rx_idle_on);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    tally_t want;
    tally_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.count      = m_axis_tdata[15:0];
      got.has_room   = m_axis_tdata[16];
      got.found      = m_axis_tdata[17];
      got.table_full = m_axis_tdata[18];
      got.used_slots = m_axis_tdata[25:19];
      if (tally_queue.size() == 0) begin
        flag_mismatch("unexpected result", 64'(m_axis_tdata), 64'(0));
      end else begin
        want = tally_queue.pop_front();
        if (got.count !== want.count)
          flag_mismatch("count", 64'(got.count), 64'(want.count));
        if (got.has_room !== want.has_room)
          flag_mismatch("has_room", 64'(got.has_room), 64'(want.has_room));
        if (got.found !== want.found)
          flag_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.table_full !== want.table_full)
          flag_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
        if (got.used_slots !== want.used_slots)
          flag_mismatch("used_slots", 64'(got.used_slots), 64'(want.used_slots));
        if (want.found) hits_seen++;
        if (want.table_full) full_seen++;
        if (want.count == COUNT_MAX) saturated_seen++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("run stopped at cycle %0d with %0d results pending", cycles, tally_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] chain_keys [SLOTS];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_live[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_cnt[i] = '0;
    end
    occupancy = 0;
    cap_shadow = 16'd8;

    // extremes, key zero, chains on one home slot, wrap past the last slot
    add_row(OP_QUERY,   64'h1,                     1, 0, 1, 0, 0, 0);
    add_row(OP_ACCOUNT, '1,                        1, 1, 1, 0, 0, 1);
    add_row(OP_ACCOUNT, '1,                        1, 2, 1, 1, 0, 1);
    add_row(OP_ACCOUNT, 64'h0,                     1, 1, 1, 0, 0, 2);
    add_row(OP_QUERY,   64'h0,                     1, 1, 1, 1, 0, 2);
    add_row(OP_SPARE,   '1,                        1, 2, 1, 1, 0, 2);
    add_row(OP_ACCOUNT, 64'h0000_0001_0000_0001,   1, 1, 1, 0, 0, 3);
    add_row(OP_QUERY,   64'h0000_0002_0000_0002,   1, 0, 1, 0, 0, 3);
    add_row(OP_ACCOUNT, 64'h8000_0000_0000_0000,   0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,   64'h5555_5555_AAAA_AAAA,   0, 0, 0, 0, 0, 0);
    add_row(OP_ACCOUNT, 64'hAAAA_AAAA_5555_5555,   0, 0, 0, 0, 0, 0);
    add_row(OP_ACCOUNT, 64'h8000_0000_0000_0000,   0, 0, 0, 0, 0, 0);
    add_row(OP_CLEAR,   64'hDEAD_BEEF_0BAD_F00D,   1, 0, 1, 0, 0, 0);
    add_row(OP_QUERY,   '1,                        1, 0, 1, 0, 0, 0);
    add_row(OP_ACCOUNT, 64'h0000_003F_0000_0000,   0, 0, 0, 0, 0, 0);
    add_row(OP_ACCOUNT, 64'h0000_0000_0000_003F,   0, 0, 0, 0, 0, 0);
    add_row(OP_ACCOUNT, 64'h0000_0001_0000_003E,   0, 0, 0, 0, 0, 0);
    add_row(OP_QUERY,   64'h0000_0001_0000_003E,   0, 0, 0, 0, 0, 0);
    add_row(OP_SPARE,   64'h0000_0000_0000_003F,   0, 0, 0, 0, 0, 0);
    add_row(OP_CLEAR,   '0,                        1, 0, 1, 0, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[i]) send_item(probe_rows[i].op, probe_rows[i].key,
                                      probe_rows[i].typed, probe_rows[i].want);
    wait_idle();

    // fill every slot from one home slot, then push past a full table
    for (int i = 0; i < SLOTS; i++) begin
      k = any_key();
      k[11:6] = 6'(i);
      k[5:0] = k[37:32] ^ 6'd5;
      chain_keys[i] = k;
      send_item(OP_ACCOUNT, k, 1'b0, '0);
    end
    send_item(OP_ACCOUNT, ~chain_keys[0], 1'b0, '0);
    send_item(OP_ACCOUNT, any_key(), 1'b0, '0);
    send_item(OP_QUERY, ~chain_keys[1], 1'b0, '0);
    send_item(OP_SPARE, chain_keys[SLOTS-1], 1'b0, '0);
    send_item(OP_ACCOUNT, chain_keys[SLOTS-1], 1'b0, '0);
    send_item(OP_CLEAR, any_key(), 1'b0, '0);
    wait_idle();

    // bump one counter past the cap with no idling
    write_region_cap({16'($urandom_range(0, 65535)), 16'h0020});
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    k = any_key();
    for (int n = 0; n < 40; n++) send_item(OP_ACCOUNT, k, 1'b0, '0);
    send_item(OP_QUERY, k, 1'b0, '0);
    wait_idle();

    write_region_cap({16'($urandom_range(0, 65535)), 16'h0000});
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(230, 20, 8);

    write_region_cap({16'($urandom_range(0, 65535)), 16'hFFFF});
    run_random(280, 100, 6);

    write_region_cap({16'($urandom_range(0, 65535)), 16'h0001});
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random(180, 40, 10);

    write_region_cap({16'($urandom_range(0, 65535)), 16'($urandom_range(2, 40))});
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random(300, 70, 5);

    if (tally_queue.size() != 0)
      flag_mismatch("results never returned", 64'(tally_queue.size()), 64'(0));
    $display("sent %0d items over directed, full-table, back-to-back and random phases",
             items_sent);
    $display("checked %0d results: %0d hits, %0d full-table rejects, %0d saturated counts",
             results_seen, hits_seen, full_seen, saturated_seen);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
